// File: sv/boris_particle_pusher_2d3v_assert.svh
// assertion macros for the boris pusher
`ifndef BORIS_PARTICLE_PUSHER_2D3V_ASSERT_SVH
`define BORIS_PARTICLE_PUSHER_2D3V_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define BPP_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("bpp check failed");

// next-cycle implication
`define BPP_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("bpp check failed");

`endif

// File: sv/bpp_pkg.sv
`timescale 1ns / 1ps
package bpp_pkg;

  localparam int DEN_W = 49;
  localparam int NUM_W = 50;
  localparam int QUO_W = 17;

  localparam logic REG_K  = 1'b0;
  localparam logic REG_DT = 1'b1;

  typedef logic signed [31:0] bpp_q_t;
  typedef logic [NUM_W-1:0] bpp_num_t;

  typedef struct packed {
    bpp_q_t pos_x;
    bpp_q_t pos_y;
    bpp_q_t vel_x;
    bpp_q_t vel_y;
    bpp_q_t vel_z;
    bpp_q_t efield_x;
    bpp_q_t efield_y;
    bpp_q_t bfield_x;
    bpp_q_t bfield_y;
    bpp_q_t bfield_z;
    logic   last_particle;
  } bpp_in_t;

  typedef struct packed {
    bpp_q_t new_pos_x;
    bpp_q_t new_pos_y;
    bpp_q_t new_vel_x;
    bpp_q_t new_vel_y;
    bpp_q_t new_vel_z;
    logic   last_out;
  } bpp_out_t;

  typedef struct packed {
    bpp_q_t [2:0] vm;
    bpp_q_t [2:0] vp;
    bpp_q_t       kx;
    bpp_q_t       ky;
    bpp_q_t       px;
    bpp_q_t       py;
    logic         last;
  } bpp_side_t;

  function automatic bpp_q_t sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

  // rounded q16.16 product
  function automatic logic signed [47:0] qmul(input bpp_q_t a, input bpp_q_t b);
    logic signed [63:0] prod;
    logic signed [63:0] rnd;
    prod = 64'(a) * 64'(b);
    rnd  = (prod + 64'sd32768) >>> 16;
    return rnd[47:0];
  endfunction

endpackage

// File: sv/bpp_cfg.sv
`timescale 1ns / 1ps
module bpp_cfg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  output bpp_pkg::bpp_q_t k_val,
  output bpp_pkg::bpp_q_t dt_val
);
  import bpp_pkg::*;

  bpp_q_t k_r;
  bpp_q_t dt_r;
  logic   wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign k_val  = k_r;
  assign dt_val = dt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r  <= '0;
      dt_r <= '0;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_K:   k_r  <= pwdata;
        REG_DT:  dt_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_K:   prdata = k_r;
      REG_DT:  prdata = dt_r;
      default: prdata = '0;
    endcase
  end

  // low address bits select nothing
  logic unused_addr;
  assign unused_addr = ^paddr[1:0];

endmodule

// File: sv/bpp_div.sv
`timescale 1ns / 1ps
module bpp_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  bpp_pkg::bpp_num_t             in_num [3],
  input  logic [bpp_pkg::DEN_W-1:0]     in_den,
  input  logic [2:0]                    in_neg,
  input  bpp_pkg::bpp_side_t            in_side,
  output logic                          out_vld,
  output logic [bpp_pkg::QUO_W-1:0]     out_quo [3],
  output logic [2:0]                    out_neg,
  output bpp_pkg::bpp_side_t            out_side
);
  import bpp_pkg::*;

  logic [NUM_W-1:0] rem_r [QUO_W][3];
  logic [QUO_W-1:0] quo_r [QUO_W][3];
  logic [QUO_W-1:0] num_r [QUO_W][3];
  logic [DEN_W-1:0] den_r [QUO_W];
  logic [2:0]       neg_r [QUO_W];
  bpp_side_t        side_r [QUO_W];
  logic [QUO_W-1:0] vld_r;

  // one quotient bit per stage, restoring
  for (genvar j = 0; j < QUO_W; j++) begin : g_stg
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [NUM_W-1:0] rem_in;
      logic [NUM_W-1:0] trial;
      logic [QUO_W-1:0] quo_in;
      logic [QUO_W-1:0] num_in;
      logic [DEN_W-1:0] den_in;
      logic             ge;
      if (j == 0) begin : g_first
        assign rem_in = NUM_W'(in_num[l][NUM_W-1:QUO_W]);
        assign quo_in = '0;
        assign num_in = in_num[l][QUO_W-1:0];
        assign den_in = in_den;
      end else begin : g_next
        assign rem_in = rem_r[j-1][l];
        assign quo_in = quo_r[j-1][l];
        assign num_in = num_r[j-1][l];
        assign den_in = den_r[j-1];
      end
      assign trial = {rem_in[NUM_W-2:0], num_in[QUO_W-1-j]};
      assign ge    = trial >= NUM_W'(den_in);
      always_ff @(posedge clk) begin
        rem_r[j][l] <= ge ? trial - NUM_W'(den_in) : trial;
        quo_r[j][l] <= {quo_in[QUO_W-2:0], ge};
        num_r[j][l] <= num_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    den_r[0]  <= in_den;
    neg_r[0]  <= in_neg;
    side_r[0] <= in_side;
    for (int j = 1; j < QUO_W; j++) begin
      den_r[j]  <= den_r[j-1];
      neg_r[j]  <= neg_r[j-1];
      side_r[j] <= side_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[QUO_W-2:0], in_vld};
    end
  end

  assign out_vld  = vld_r[QUO_W-1];
  assign out_neg  = neg_r[QUO_W-1];
  assign out_side = side_r[QUO_W-1];
  for (genvar l = 0; l < 3; l++) begin : g_out
    assign out_quo[l] = quo_r[QUO_W-1][l];
  end

endmodule

// File: sv/boris_particle_pusher_2d3v.sv
// boris particle pusher, 2d position and 3d velocity, signed q16.16
// input: one particle per beat, taken at a clock edge where start is high
// and busy is low; busy stays low, so a particle may enter every cycle
// output: out_valid marks one result beat in out_data, one per particle,
// in arrival order; the receiver takes it in that cycle and cannot stall
// throughput one per cycle; the pipeline depth is set by the
// 17-stage restoring divider for s = 2t/(1+|t|^2) plus seven multiply
// and saturate stages around it
// config: apb port, k (q/m * dt/2) at address 0, dt at address 4; the user
// writes them only while no particle is in flight, not enforced; both read back
// reset: synchronous active-low rst_n clears all stage valids and both
// registers; particles in flight are dropped
`timescale 1ns / 1ps
`include "boris_particle_pusher_2d3v_assert.svh"
module boris_particle_pusher_2d3v (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  bpp_pkg::bpp_in_t  in_data,
  output logic              out_valid,
  output bpp_pkg::bpp_out_t out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import bpp_pkg::*;

  localparam int LATENCY = QUO_W + 7;

  bpp_q_t k_val;
  bpp_q_t dt_val;
  logic   acc;

  bpp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .k_val   (k_val),
    .dt_val  (dt_val)
  );

  assign busy = 1'b0;
  assign acc  = start && !busy;

  // stage 1: t = k*b, kick = k*e
  logic   s1_vld_r;
  bpp_q_t s1_t_r [3];
  bpp_q_t s1_v_r [3];
  bpp_q_t s1_kx_r, s1_ky_r, s1_px_r, s1_py_r;
  logic   s1_last_r;
  bpp_q_t s1_t_nxt [3];
  bpp_q_t s1_b [3];

  assign s1_b[0] = in_data.bfield_x;
  assign s1_b[1] = in_data.bfield_y;
  assign s1_b[2] = in_data.bfield_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s1_t_nxt[i] = sat32(64'(qmul(k_val, s1_b[i])));
    end
  end

  always_ff @(posedge clk) begin
    s1_t_r    <= s1_t_nxt;
    s1_v_r[0] <= in_data.vel_x;
    s1_v_r[1] <= in_data.vel_y;
    s1_v_r[2] <= in_data.vel_z;
    s1_kx_r   <= sat32(64'(qmul(k_val, in_data.efield_x)));
    s1_ky_r   <= sat32(64'(qmul(k_val, in_data.efield_y)));
    s1_px_r   <= in_data.pos_x;
    s1_py_r   <= in_data.pos_y;
    s1_last_r <= in_data.last_particle;
  end

  // stage 2: squares of t, v minus
  logic                s2_vld_r;
  logic signed [47:0]  s2_sq_r [3];
  bpp_q_t              s2_t_r [3];
  bpp_q_t              s2_vm_r [3];
  bpp_q_t              s2_kx_r, s2_ky_r, s2_px_r, s2_py_r;
  logic                s2_last_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s2_sq_r[i] <= qmul(s1_t_r[i], s1_t_r[i]);
    end
    s2_t_r     <= s1_t_r;
    s2_vm_r[0] <= sat32(64'(s1_v_r[0]) + 64'(s1_kx_r));
    s2_vm_r[1] <= sat32(64'(s1_v_r[1]) + 64'(s1_ky_r));
    s2_vm_r[2] <= s1_v_r[2];
    s2_kx_r    <= s1_kx_r;
    s2_ky_r    <= s1_ky_r;
    s2_px_r    <= s1_px_r;
    s2_py_r    <= s1_py_r;
    s2_last_r  <= s1_last_r;
  end

  // stage 3: divisor, products of v minus x t
  logic               s3_vld_r;
  logic [DEN_W-1:0]   s3_den_r;
  logic signed [47:0] s3_c_r [6];
  bpp_q_t             s3_t_r [3];
  bpp_q_t             s3_vm_r [3];
  bpp_q_t             s3_kx_r, s3_ky_r, s3_px_r, s3_py_r;
  logic               s3_last_r;

  always_ff @(posedge clk) begin
    s3_den_r  <= DEN_W'(s2_sq_r[0]) + DEN_W'(s2_sq_r[1]) + DEN_W'(s2_sq_r[2])
                 + DEN_W'(65536);
    s3_c_r[0] <= qmul(s2_vm_r[1], s2_t_r[2]);
    s3_c_r[1] <= qmul(s2_vm_r[2], s2_t_r[1]);
    s3_c_r[2] <= qmul(s2_vm_r[2], s2_t_r[0]);
    s3_c_r[3] <= qmul(s2_vm_r[0], s2_t_r[2]);
    s3_c_r[4] <= qmul(s2_vm_r[0], s2_t_r[1]);
    s3_c_r[5] <= qmul(s2_vm_r[1], s2_t_r[0]);
    s3_t_r    <= s2_t_r;
    s3_vm_r   <= s2_vm_r;
    s3_kx_r   <= s2_kx_r;
    s3_ky_r   <= s2_ky_r;
    s3_px_r   <= s2_px_r;
    s3_py_r   <= s2_py_r;
    s3_last_r <= s2_last_r;
  end

  // stage 4: v prime, rounded dividends into the divider
  bpp_num_t  d_num [3];
  logic [2:0] d_neg;
  bpp_side_t d_side;
  bpp_q_t    s4_vp [3];
  logic [31:0] s4_mag [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s4_vp[i]  = sat32(64'(s3_vm_r[i])
                  + 64'(sat32(64'(s3_c_r[2*i]) - 64'(s3_c_r[2*i+1]))));
      s4_mag[i] = s3_t_r[i][31] ? (~s3_t_r[i] + 32'd1) : s3_t_r[i];
      d_num[i]  = NUM_W'({s4_mag[i], 17'd0}) + NUM_W'(s3_den_r[DEN_W-1:1]);
      d_neg[i]  = s3_t_r[i][31];
    end
    d_side.vm   = {s3_vm_r[2], s3_vm_r[1], s3_vm_r[0]};
    d_side.vp   = {s4_vp[2], s4_vp[1], s4_vp[0]};
    d_side.kx   = s3_kx_r;
    d_side.ky   = s3_ky_r;
    d_side.px   = s3_px_r;
    d_side.py   = s3_py_r;
    d_side.last = s3_last_r;
  end

  logic             q_vld;
  logic [QUO_W-1:0] q_quo [3];
  logic [2:0]       q_neg;
  bpp_side_t        q_side;

  bpp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s3_vld_r),
    .in_num   (d_num),
    .in_den   (s3_den_r),
    .in_neg   (d_neg),
    .in_side  (d_side),
    .out_vld  (q_vld),
    .out_quo  (q_quo),
    .out_neg  (q_neg),
    .out_side (q_side)
  );

  // stage 5: products of v prime x s
  bpp_q_t             s5_s [3];
  bpp_q_t             s5_vp [3];
  logic               s5_vld_r;
  logic signed [47:0] s5_c_r [6];
  bpp_side_t          s5_side_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s5_s[i]  = q_neg[i] ? -$signed(32'(q_quo[i])) : $signed(32'(q_quo[i]));
      s5_vp[i] = $signed(q_side.vp[i]);
    end
  end

  always_ff @(posedge clk) begin
    s5_c_r[0] <= qmul(s5_vp[1], s5_s[2]);
    s5_c_r[1] <= qmul(s5_vp[2], s5_s[1]);
    s5_c_r[2] <= qmul(s5_vp[2], s5_s[0]);
    s5_c_r[3] <= qmul(s5_vp[0], s5_s[2]);
    s5_c_r[4] <= qmul(s5_vp[0], s5_s[1]);
    s5_c_r[5] <= qmul(s5_vp[1], s5_s[0]);
    s5_side_r <= q_side;
  end

  // stage 6: v plus, second half kick
  bpp_q_t s6_vplus [3];
  logic   s6_vld_r;
  bpp_q_t s6_nv_r [3];
  bpp_q_t s6_px_r, s6_py_r;
  logic   s6_last_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s6_vplus[i] = sat32(64'($signed(s5_side_r.vm[i]))
                    + 64'(sat32(64'(s5_c_r[2*i]) - 64'(s5_c_r[2*i+1]))));
    end
  end

  always_ff @(posedge clk) begin
    s6_nv_r[0] <= sat32(64'(s6_vplus[0]) + 64'($signed(s5_side_r.kx)));
    s6_nv_r[1] <= sat32(64'(s6_vplus[1]) + 64'($signed(s5_side_r.ky)));
    s6_nv_r[2] <= s6_vplus[2];
    s6_px_r    <= s5_side_r.px;
    s6_py_r    <= s5_side_r.py;
    s6_last_r  <= s5_side_r.last;
  end

  // stage 7: position step
  logic   s7_vld_r;
  bpp_q_t s7_dx_r, s7_dy_r;
  bpp_q_t s7_nv_r [3];
  bpp_q_t s7_px_r, s7_py_r;
  logic   s7_last_r;

  always_ff @(posedge clk) begin
    s7_dx_r   <= sat32(64'(qmul(s6_nv_r[0], dt_val)));
    s7_dy_r   <= sat32(64'(qmul(s6_nv_r[1], dt_val)));
    s7_nv_r   <= s6_nv_r;
    s7_px_r   <= s6_px_r;
    s7_py_r   <= s6_py_r;
    s7_last_r <= s6_last_r;
  end

  // output register
  logic     out_vld_r;
  bpp_out_t out_r;

  always_ff @(posedge clk) begin
    out_r.new_pos_x <= sat32(64'(s7_px_r) + 64'(s7_dx_r));
    out_r.new_pos_y <= sat32(64'(s7_py_r) + 64'(s7_dy_r));
    out_r.new_vel_x <= s7_nv_r[0];
    out_r.new_vel_y <= s7_nv_r[1];
    out_r.new_vel_z <= s7_nv_r[2];
    out_r.last_out  <= s7_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s5_vld_r  <= 1'b0;
      s6_vld_r  <= 1'b0;
      s7_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= acc;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      s5_vld_r  <= q_vld;
      s6_vld_r  <= s5_vld_r;
      s7_vld_r  <= s6_vld_r;
      out_vld_r <= s7_vld_r;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  `BPP_ASSERT_IMP(a_out_has_src, out_valid, $past(acc, LATENCY))
  `BPP_ASSERT_IMP(a_last_thru, out_valid, out_data.last_out == $past(in_data.last_particle, LATENCY))
  `BPP_ASSERT_IMP(a_quo_range, q_vld, (q_quo[0] <= 17'd65536) && (q_quo[1] <= 17'd65536) && (q_quo[2] <= 17'd65536))
  `BPP_ASSERT_NXT(a_div_to_s5, q_vld, s5_vld_r)

endmodule
